// ===== rtl/core/npr_pkg.sv =====
// Shared types and fixed widths for the nearest-point-to-ray pick unit.
package npr_pkg;

    localparam int COORD_W  = 20;  // point and origin coordinates, signed Q10.10
    localparam int DIR_W    = 18;  // direction components, signed Q2.16
    localparam int DIR_FRAC = 16;
    localparam int DIFF_W   = COORD_W + 1;           // point minus origin
    localparam int PROD_W   = DIFF_W + DIR_W;        // one cross-product term
    localparam int CRS_W    = PROD_W + 1;            // difference of two terms
    localparam int CQ_W     = CRS_W - DIR_FRAC;      // cross component back at Q.10
    localparam int CSQ_W    = 2 * CQ_W;              // its square
    localparam int PERP_W   = CSQ_W + 2;             // sum of three squares
    localparam int DSQ_W    = 2 * DIFF_W;            // square of one offset
    localparam int DIST_W   = DSQ_W + 1;             // sum of three offset squares
    localparam int RAD_W    = 42;                    // radius and distance registers
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 42;

    localparam logic [CFG_AW-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_AW-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_AW-1:0] REG_DIR_X    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_DIR_Y    = 3'd4;
    localparam logic [CFG_AW-1:0] REG_DIR_Z    = 3'd5;
    localparam logic [CFG_AW-1:0] REG_RADIUS   = 3'd6;
    localparam logic [CFG_AW-1:0] REG_MAX_DIST = 3'd7;

    localparam logic [DIR_W-1:0] DIR_Z_RST    = 18'd65536;
    localparam logic [RAD_W-1:0] RADIUS_RST   = 42'd10486;
    localparam logic [RAD_W-1:0] MAX_DIST_RST = 42'd1048576000000;

    // Ray setup seen by the distance pipeline.
    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
        logic [RAD_W-1:0]          radius_sq;
    } t_ray_cfg;

    // Classified candidate passed from front to back.
    typedef struct packed {
        logic                      hit;
        logic                      last;
        logic [DIST_W-1:0]         dist_sq;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_cand;

endpackage

// ===== rtl/core/npr_front.sv =====
// Distance pipeline: offset, cross product, squares, radius test.
module npr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  npr_pkg::t_ray_cfg             i_cfg,
    input  logic                          i_valid,
    input  logic signed [npr_pkg::COORD_W-1:0] i_x,
    input  logic signed [npr_pkg::COORD_W-1:0] i_y,
    input  logic signed [npr_pkg::COORD_W-1:0] i_z,
    input  logic                          i_last,
    input  logic                          i_adv,
    output logic                          o_valid,
    output npr_pkg::t_cand                o_cand
);
    import npr_pkg::*;

    // stage 1: offsets
    logic                      r_v1, r_l1;
    logic signed [COORD_W-1:0] r_x1, r_y1, r_z1;
    logic signed [DIFF_W-1:0]  r_dx1, r_dy1, r_dz1;
    // stage 2: cross-product terms
    logic                      r_v2, r_l2;
    logic signed [COORD_W-1:0] r_x2, r_y2, r_z2;
    logic signed [DIFF_W-1:0]  r_dx2, r_dy2, r_dz2;
    logic signed [PROD_W-1:0]  r_uydz, r_uzdy, r_uzdx, r_uxdz, r_uxdy, r_uydx;
    // stage 3: cross components at Q.10
    logic                      r_v3, r_l3;
    logic signed [COORD_W-1:0] r_x3, r_y3, r_z3;
    logic signed [DIFF_W-1:0]  r_dx3, r_dy3, r_dz3;
    logic signed [CQ_W-1:0]    r_cx, r_cy, r_cz;
    // stage 4: squares
    logic                      r_v4, r_l4;
    logic signed [COORD_W-1:0] r_x4, r_y4, r_z4;
    logic signed [CSQ_W-1:0]   r_csx, r_csy, r_csz;
    logic signed [DSQ_W-1:0]   r_dsx, r_dsy, r_dsz;

    logic signed [CRS_W-1:0]   crs_x, crs_y, crs_z;
    logic [PERP_W-1:0]         perp_sq;
    logic [DIST_W-1:0]         dist_sq;

    // floor by 2^16 is the upper slice of the two's complement value
    assign crs_x = CRS_W'(r_uydz) - CRS_W'(r_uzdy);
    assign crs_y = CRS_W'(r_uzdx) - CRS_W'(r_uxdz);
    assign crs_z = CRS_W'(r_uxdy) - CRS_W'(r_uydx);

    assign perp_sq = {2'b00, r_csx} + {2'b00, r_csy} + {2'b00, r_csz};
    assign dist_sq = {1'b0, r_dsx} + {1'b0, r_dsy} + {1'b0, r_dsz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_l1  <= i_last;
            r_x1  <= i_x;
            r_y1  <= i_y;
            r_z1  <= i_z;
            r_dx1 <= DIFF_W'(i_x) - DIFF_W'(i_cfg.origin_x);
            r_dy1 <= DIFF_W'(i_y) - DIFF_W'(i_cfg.origin_y);
            r_dz1 <= DIFF_W'(i_z) - DIFF_W'(i_cfg.origin_z);

            r_l2   <= r_l1;
            r_x2   <= r_x1;
            r_y2   <= r_y1;
            r_z2   <= r_z1;
            r_dx2  <= r_dx1;
            r_dy2  <= r_dy1;
            r_dz2  <= r_dz1;
            r_uydz <= i_cfg.dir_y * r_dz1;
            r_uzdy <= i_cfg.dir_z * r_dy1;
            r_uzdx <= i_cfg.dir_z * r_dx1;
            r_uxdz <= i_cfg.dir_x * r_dz1;
            r_uxdy <= i_cfg.dir_x * r_dy1;
            r_uydx <= i_cfg.dir_y * r_dx1;

            r_l3  <= r_l2;
            r_x3  <= r_x2;
            r_y3  <= r_y2;
            r_z3  <= r_z2;
            r_dx3 <= r_dx2;
            r_dy3 <= r_dy2;
            r_dz3 <= r_dz2;
            r_cx  <= crs_x[CRS_W-1:DIR_FRAC];
            r_cy  <= crs_y[CRS_W-1:DIR_FRAC];
            r_cz  <= crs_z[CRS_W-1:DIR_FRAC];

            r_l4  <= r_l3;
            r_x4  <= r_x3;
            r_y4  <= r_y3;
            r_z4  <= r_z3;
            r_csx <= r_cx * r_cx;
            r_csy <= r_cy * r_cy;
            r_csz <= r_cz * r_cz;
            r_dsx <= r_dx3 * r_dx3;
            r_dsy <= r_dy3 * r_dy3;
            r_dsz <= r_dz3 * r_dz3;
        end
    end

    assign o_valid        = r_v4;
    assign o_cand.hit     = perp_sq < {{(PERP_W-RAD_W){1'b0}}, i_cfg.radius_sq};
    assign o_cand.last    = r_l4;
    assign o_cand.dist_sq = dist_sq;
    assign o_cand.x       = r_x4;
    assign o_cand.y       = r_y4;
    assign o_cand.z       = r_z4;

endmodule

// ===== rtl/core/npr_queue.sv =====
// Small word queue between the distance pipeline and the best-point tracker.
module npr_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  npr_pkg::t_cand i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output npr_pkg::t_cand o_data
);
    import npr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cand         r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST_IDX) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("queue count out of range");

endmodule

// ===== rtl/core/npr_back.sv =====
// Best-point tracker and result register.
module npr_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [npr_pkg::RAD_W-1:0]          i_max_dist_sq,
    input  logic                               i_q_empty,
    input  npr_pkg::t_cand                     i_cand,
    output logic                               o_q_pop,
    input  logic                               i_pop,
    output logic                               o_empty,
    output logic                               o_found,
    output logic signed [npr_pkg::COORD_W-1:0] o_pick_x,
    output logic signed [npr_pkg::COORD_W-1:0] o_pick_y,
    output logic signed [npr_pkg::COORD_W-1:0] o_pick_z
);
    import npr_pkg::*;

    logic [RAD_W-1:0]          r_best_dist;
    logic signed [COORD_W-1:0] r_best_x, r_best_y, r_best_z;
    logic                      r_hit;
    logic                      r_out_v;

    logic                      take;
    logic                      n_hit;
    logic signed [COORD_W-1:0] n_best_x, n_best_y, n_best_z;
    logic                      out_free;

    // a closing word needs the result register free
    assign out_free = !r_out_v || i_pop;
    assign o_q_pop  = !i_q_empty && (!i_cand.last || out_free);

    // ties keep the earlier point
    assign take     = i_cand.hit && (i_cand.dist_sq < {1'b0, r_best_dist});
    assign n_hit    = r_hit || take;
    assign n_best_x = take ? i_cand.x : r_best_x;
    assign n_best_y = take ? i_cand.y : r_best_y;
    assign n_best_z = take ? i_cand.z : r_best_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_dist <= MAX_DIST_RST;
            r_hit       <= 1'b0;
            r_out_v     <= 1'b0;
        end else begin
            if (i_pop) begin
                r_out_v <= 1'b0;
            end
            if (o_q_pop) begin
                if (i_cand.last) begin
                    r_best_dist <= i_max_dist_sq;
                    r_hit       <= 1'b0;
                    r_out_v     <= 1'b1;
                end else begin
                    if (take) begin
                        r_best_dist <= i_cand.dist_sq[RAD_W-1:0];
                    end
                    r_hit <= n_hit;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_best_x <= n_best_x;
            r_best_y <= n_best_y;
            r_best_z <= n_best_z;
            if (i_cand.last) begin
                o_found  <= n_hit;
                o_pick_x <= n_hit ? n_best_x : '0;
                o_pick_y <= n_hit ? n_best_y : '0;
                o_pick_z <= n_hit ? n_best_z : '0;
            end
        end
    end

    assign o_empty = !r_out_v;

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !o_found) |-> (o_pick_x == '0 && o_pick_y == '0 && o_pick_z == '0))
        else $error("result without a hit carries a point");
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_cand.last) |=> (r_out_v && !r_hit))
        else $error("tracker not rearmed after closing word");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && i_cand.last) |-> (!r_out_v || i_pop))
        else $error("pending result overwritten");

endmodule

// ===== rtl/core/nearest_point_to_ray_pick_unit.sv =====
// Top level of the nearest-point-to-ray pick unit: register file, pipeline, queue, tracker.
//
// Candidate points enter on push/full, one word per cycle while full is low. Each point goes
// through a four-stage distance pipeline (offset from the ray origin, the six
// direction-by-offset products, cross components floored to Q.10, then their squares and the
// squared offsets), and the squared perpendicular distance is tested against radius_sq as the
// word is written into a QUEUE_DEPTH-word queue. The tracker behind the queue takes one word
// per cycle, but a closing word waits until the result register is free; its compare of the
// squared origin distance against the best so far is the only feedback loop. A point marked
// last_point closes the pick: the result (found flag and chosen point, zeros on a miss) lands
// in a one-word result register read via empty/pop, and the tracker reloads max_dist_sq. full
// rises only when the queue has filled, which happens when results are not popped. Ray
// registers are written on i_cfg_we and must only change while no pick is in flight;
// max_dist_sq is picked up at the next rearm. Ties keep the first point seen.
module nearest_point_to_ray_pick_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [npr_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [npr_pkg::CFG_DW-1:0]         i_cfg_data,
    // candidate points
    input  logic                               push,
    output logic                               full,
    input  logic signed [npr_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [npr_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [npr_pkg::COORD_W-1:0] i_point_z,
    input  logic                               i_last_point,
    // pick results
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_found,
    output logic signed [npr_pkg::COORD_W-1:0] o_pick_x,
    output logic signed [npr_pkg::COORD_W-1:0] o_pick_y,
    output logic signed [npr_pkg::COORD_W-1:0] o_pick_z
);
    import npr_pkg::*;

    t_ray_cfg         r_cfg;
    logic [RAD_W-1:0] r_max_dist;

    logic  adv;
    logic  fe_valid;
    t_cand fe_cand;
    logic  q_full, q_empty, q_pop;
    t_cand q_head;

    // register file; all eight indexes are mapped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x  <= '0;
            r_cfg.origin_y  <= '0;
            r_cfg.origin_z  <= '0;
            r_cfg.dir_x     <= '0;
            r_cfg.dir_y     <= '0;
            r_cfg.dir_z     <= DIR_Z_RST;
            r_cfg.radius_sq <= RADIUS_RST;
            r_max_dist      <= MAX_DIST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ORIGIN_X: r_cfg.origin_x  <= i_cfg_data[COORD_W-1:0];
                REG_ORIGIN_Y: r_cfg.origin_y  <= i_cfg_data[COORD_W-1:0];
                REG_ORIGIN_Z: r_cfg.origin_z  <= i_cfg_data[COORD_W-1:0];
                REG_DIR_X:    r_cfg.dir_x     <= i_cfg_data[DIR_W-1:0];
                REG_DIR_Y:    r_cfg.dir_y     <= i_cfg_data[DIR_W-1:0];
                REG_DIR_Z:    r_cfg.dir_z     <= i_cfg_data[DIR_W-1:0];
                REG_RADIUS:   r_cfg.radius_sq <= i_cfg_data[RAD_W-1:0];
                REG_MAX_DIST: r_max_dist      <= i_cfg_data[RAD_W-1:0];
                default:      r_max_dist      <= r_max_dist;
            endcase
        end
    end

    // whole pipeline holds while the queue is full
    assign adv  = !q_full;
    assign full = q_full;

    npr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (push && adv),
        .i_x     (i_point_x),
        .i_y     (i_point_y),
        .i_z     (i_point_z),
        .i_last  (i_last_point),
        .i_adv   (adv),
        .o_valid (fe_valid),
        .o_cand  (fe_cand)
    );

    npr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_valid && adv),
        .i_data  (fe_cand),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_head)
    );

    npr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_max_dist_sq (r_max_dist),
        .i_q_empty     (q_empty),
        .i_cand        (q_head),
        .o_q_pop       (q_pop),
        .i_pop         (pop && !empty),
        .o_empty       (empty),
        .o_found       (o_found),
        .o_pick_x      (o_pick_x),
        .o_pick_y      (o_pick_y),
        .o_pick_z      (o_pick_z)
    );

endmodule
